@@ rtl/wavetable_oscillator_linear_interp_defines.svh @@
// Assertion macros used by the checker file of the wavetable oscillator.
`ifndef WAVETABLE_OSCILLATOR_LINEAR_INTERP_DEFINES_SVH
`define WAVETABLE_OSCILLATOR_LINEAR_INTERP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define WOLIN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define WOLIN_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/wolin_pkg.sv @@
// Package with the shared constants and codes of the wavetable oscillator.
`default_nettype none
package wolin_pkg;

  // Default geometry of the oscillator.
  localparam int TABLE_SIZE_LOG2_DEF = 11;
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int FRACTION_BITS_DEF   = 16;

  // Log2 of the depth of the command queue between the front and back parts.
  localparam int QUEUE_DEPTH_LOG2 = 2;

  // Input item action codes.
  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_WRITE = 3'd1,
    ACT_STEP  = 3'd2,
    ACT_START = 3'd3,
    ACT_STOP  = 3'd4
  } action_t;

  // Commands handed from the front part to the back part.
  typedef enum logic [1:0] {
    CMD_TICK_RUN  = 2'd0,
    CMD_TICK_IDLE = 2'd1,
    CMD_WRITE     = 2'd2
  } cmd_kind_t;

  localparam int CMD_KIND_BITS = 2;

endpackage
`default_nettype wire

@@ rtl/wolin_queue.sv @@
// Short first-in first-out queue of commands between the front and back parts.
`default_nettype none
module wolin_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  import wolin_pkg::*;

  localparam int DEPTH = 1 << QUEUE_DEPTH_LOG2;

  logic [WIDTH-1:0]            slot_r [DEPTH];
  logic [QUEUE_DEPTH_LOG2-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_DEPTH_LOG2-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_DEPTH_LOG2:0]   count_r, count_nxt;
  logic                        do_push, do_pop;

  assign full    = (count_r == (QUEUE_DEPTH_LOG2 + 1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage carries no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

@@ rtl/wolin_front.sv @@
// Front part: accepts items, keeps phase, step and run state, issues commands.
`default_nettype none
module wolin_front #(
  parameter int TABLE_SIZE_LOG2 = wolin_pkg::TABLE_SIZE_LOG2_DEF,
  parameter int SAMPLE_BITS     = wolin_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS   = wolin_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      accept,
  input  wire logic [2:0]                                action,
  input  wire logic [TABLE_SIZE_LOG2-1:0]                table_address,
  input  wire logic signed [SAMPLE_BITS-1:0]             table_value,
  input  wire logic [TABLE_SIZE_LOG2+FRACTION_BITS-1:0]  phase_step,
  output logic                                           cmd_valid,
  output wolin_pkg::cmd_kind_t                           cmd_kind,
  output logic [TABLE_SIZE_LOG2-1:0]                     cmd_addr,
  output logic [SAMPLE_BITS-1:0]                         cmd_value,
  output logic [FRACTION_BITS-1:0]                       cmd_frac
);
  import wolin_pkg::*;

  localparam int PHASE_BITS = TABLE_SIZE_LOG2 + FRACTION_BITS;

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [PHASE_BITS-1:0] step_r, step_nxt;
  logic                  running_r, running_nxt;

  // Classify the item and update the oscillator state.
  always_comb begin
    phase_nxt   = phase_r;
    step_nxt    = step_r;
    running_nxt = running_r;
    cmd_valid   = 1'b0;
    cmd_kind    = CMD_TICK_IDLE;
    cmd_addr    = phase_r[PHASE_BITS-1:FRACTION_BITS];
    cmd_value   = table_value;
    cmd_frac    = phase_r[FRACTION_BITS-1:0];
    if (accept) begin
      unique case (action)
        ACT_TICK: begin
          cmd_valid = 1'b1;
          if (running_r) begin
            cmd_kind  = CMD_TICK_RUN;
            phase_nxt = phase_r + step_r;
          end
        end
        ACT_WRITE: begin
          cmd_valid = 1'b1;
          cmd_kind  = CMD_WRITE;
          cmd_addr  = table_address;
        end
        ACT_STEP: begin
          step_nxt = phase_step;
        end
        ACT_START: begin
          running_nxt = 1'b1;
        end
        ACT_STOP: begin
          running_nxt = 1'b0;
          phase_nxt   = '0;
        end
        default: begin
          // Unused codes are dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      step_r    <= '0;
      running_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      step_r    <= step_nxt;
      running_r <= running_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/wolin_back.sv @@
// Back part: wave table, interpolation pipeline and result register.
`default_nettype none
module wolin_back #(
  parameter int TABLE_SIZE_LOG2 = wolin_pkg::TABLE_SIZE_LOG2_DEF,
  parameter int SAMPLE_BITS     = wolin_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS   = wolin_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_empty,
  output logic                                q_pop,
  input  wire wolin_pkg::cmd_kind_t           cmd_kind,
  input  wire logic [TABLE_SIZE_LOG2-1:0]     cmd_addr,
  input  wire logic [SAMPLE_BITS-1:0]         cmd_value,
  input  wire logic [FRACTION_BITS-1:0]       cmd_frac,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic signed [SAMPLE_BITS-1:0]       out_sample,
  output logic                                out_playing
);
  import wolin_pkg::*;

  localparam int TABLE_LEN = 1 << TABLE_SIZE_LOG2;
  localparam int WGT_BITS  = FRACTION_BITS + 1;
  localparam int PROD_BITS = SAMPLE_BITS + WGT_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam logic [WGT_BITS-1:0] WGT_ONE  = WGT_BITS'(1) << FRACTION_BITS;
  localparam logic [SUM_BITS-1:0] SUM_HALF = SUM_BITS'(1) << (FRACTION_BITS - 1);

  logic signed [SAMPLE_BITS-1:0] table_mem [TABLE_LEN];

  logic                          adv;
  logic                          take;
  logic [TABLE_SIZE_LOG2-1:0]    addr_next;

  logic                          s1_vld_r, s1_play_r;
  logic [FRACTION_BITS-1:0]      s1_frac_r;
  logic signed [SAMPLE_BITS-1:0] rd_a_r, rd_b_r;
  logic [WGT_BITS-1:0]           wgt_a, wgt_b;

  logic                          s2_vld_r, s2_play_r;
  logic signed [PROD_BITS-1:0]   prod_a_r, prod_b_r;
  logic [SUM_BITS-1:0]           sum_w;

  logic                          o_vld_r;
  logic signed [SAMPLE_BITS-1:0] o_sample_r;
  logic                          o_play_r;

  // The whole pipeline moves when the result register is free or being taken.
  assign adv       = !o_vld_r || out_pop;
  assign take      = adv && !q_empty;
  assign q_pop     = take;
  assign addr_next = cmd_addr + {{(TABLE_SIZE_LOG2-1){1'b0}}, 1'b1};

  // Table write and the two registered reads of neighbouring entries.
  always_ff @(posedge clk) begin
    if (take && cmd_kind == CMD_WRITE) begin
      table_mem[cmd_addr] <= cmd_value;
    end
    if (adv) begin
      rd_a_r <= table_mem[cmd_addr];
      rd_b_r <= table_mem[addr_next];
    end
  end

  // Stage one control and the fraction travelling with the reads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= take && (cmd_kind != CMD_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_play_r <= (cmd_kind == CMD_TICK_RUN);
      s1_frac_r <= cmd_frac;
    end
  end

  // Stage two: weight each neighbour by its share of the fraction.
  // The weights are unsigned and reach a full one, so they are widened with a zero.
  assign wgt_a = WGT_ONE - {1'b0, s1_frac_r};
  assign wgt_b = {1'b0, s1_frac_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_play_r <= s1_play_r;
      prod_a_r  <= PROD_BITS'(rd_a_r) * PROD_BITS'($signed({1'b0, wgt_a}));
      prod_b_r  <= PROD_BITS'(rd_b_r) * PROD_BITS'($signed({1'b0, wgt_b}));
    end
  end

  // Sum, round to nearest with ties upward, and drop the fraction; an idle tick gives zero.
  assign sum_w = {prod_a_r[PROD_BITS-1], prod_a_r} + {prod_b_r[PROD_BITS-1], prod_b_r}
               + SUM_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (adv) begin
      o_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_play_r   <= s2_play_r;
      o_sample_r <= s2_play_r ? $signed(sum_w[FRACTION_BITS +: SAMPLE_BITS]) : '0;
    end
  end

  assign out_empty   = !o_vld_r;
  assign out_sample  = o_sample_r;
  assign out_playing = o_play_r;

endmodule
`default_nettype wire

@@ rtl/wavetable_oscillator_linear_interp.sv @@
// Top level of the wavetable oscillator with linear interpolation.
//
//   Channel  Direction  Handshake         Fields
//   in_      input      in_push/in_full   action, table_address, table_value, phase_step
//   out_     output     out_pop/out_empty sample, playing
//
// One item is taken per cycle while in_full is low; the front part updates phase, step
// and run state at once. A tick result passes through the command queue and then the
// table read, product and rounding registers of the back part to the result ports.
// Reset clears phase, step, run state, the command queue and the result register; the
// wave table is not cleared. A stalled result holds the back pipeline; the front keeps
// accepting items until the four-entry command queue fills, then raises in_full.
`default_nettype none
module wavetable_oscillator_linear_interp #(
  parameter int TABLE_SIZE_LOG2 = wolin_pkg::TABLE_SIZE_LOG2_DEF,
  parameter int SAMPLE_BITS     = wolin_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS   = wolin_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_push,
  output logic                                          in_full,
  input  wire logic [2:0]                               in_action,
  input  wire logic [TABLE_SIZE_LOG2-1:0]               in_table_address,
  input  wire logic signed [SAMPLE_BITS-1:0]            in_table_value,
  input  wire logic [TABLE_SIZE_LOG2+FRACTION_BITS-1:0] in_phase_step,
  output logic                                          out_empty,
  input  wire logic                                     out_pop,
  output logic signed [SAMPLE_BITS-1:0]                 out_sample,
  output logic                                          out_playing
);
  import wolin_pkg::*;

  localparam int CMD_BITS = CMD_KIND_BITS + TABLE_SIZE_LOG2 + SAMPLE_BITS + FRACTION_BITS;

  logic                       in_accept;
  logic                       f_valid;
  cmd_kind_t                  f_kind;
  logic [TABLE_SIZE_LOG2-1:0] f_addr;
  logic [SAMPLE_BITS-1:0]     f_value;
  logic [FRACTION_BITS-1:0]   f_frac;

  logic [CMD_BITS-1:0]        q_wdata, q_rdata;
  logic                       q_empty, q_pop;

  cmd_kind_t                  b_kind;
  logic [TABLE_SIZE_LOG2-1:0] b_addr;
  logic [SAMPLE_BITS-1:0]     b_value;
  logic [FRACTION_BITS-1:0]   b_frac;

  assign in_accept = in_push && !in_full;

  wolin_front #(
    .TABLE_SIZE_LOG2(TABLE_SIZE_LOG2),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .action       (in_action),
    .table_address(in_table_address),
    .table_value  (in_table_value),
    .phase_step   (in_phase_step),
    .cmd_valid    (f_valid),
    .cmd_kind     (f_kind),
    .cmd_addr     (f_addr),
    .cmd_value    (f_value),
    .cmd_frac     (f_frac)
  );

  // Commands are packed flat for the queue and unpacked on the far side.
  assign q_wdata = {f_kind, f_addr, f_value, f_frac};

  wolin_queue #(
    .WIDTH(CMD_BITS)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (f_valid),
    .wdata(q_wdata),
    .full (in_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  assign b_kind  = cmd_kind_t'(q_rdata[CMD_BITS-1 -: CMD_KIND_BITS]);
  assign b_addr  = q_rdata[FRACTION_BITS+SAMPLE_BITS +: TABLE_SIZE_LOG2];
  assign b_value = q_rdata[FRACTION_BITS +: SAMPLE_BITS];
  assign b_frac  = q_rdata[FRACTION_BITS-1:0];

  wolin_back #(
    .TABLE_SIZE_LOG2(TABLE_SIZE_LOG2),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .cmd_kind   (b_kind),
    .cmd_addr   (b_addr),
    .cmd_value  (b_value),
    .cmd_frac   (b_frac),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_sample (out_sample),
    .out_playing(out_playing)
  );

endmodule
`default_nettype wire

@@ rtl/wolin_chk.sv @@
// Port-level checker for the wavetable oscillator, bound to the top level.
`default_nettype none
`include "wavetable_oscillator_linear_interp_defines.svh"
module wolin_chk #(
  parameter int SAMPLE_BITS = wolin_pkg::SAMPLE_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_full,
  input wire logic                   out_empty,
  input wire logic                   out_pop,
  input wire logic [SAMPLE_BITS-1:0] out_sample,
  input wire logic                   out_playing
);

  // A tick taken while stopped yields a silent sample.
  `WOLIN_ASSERT(a_idle_silent, (!out_empty && !out_playing) |-> (out_sample == '0), "stopped tick gave a non-zero sample")

  // Reset leaves no result waiting.
  `WOLIN_ASSERT_RST(a_rst_empty, !rst_n |=> out_empty, "result waiting after reset")

  // Reset leaves the command queue with room.
  `WOLIN_ASSERT_RST(a_rst_room, !rst_n |=> !in_full, "input full after reset")

  // A waiting result that is not taken stays in place unchanged.
  `WOLIN_ASSERT(a_hold, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_sample) && $stable(out_playing)), "waiting result changed or vanished")

endmodule

bind wavetable_oscillator_linear_interp wolin_chk #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_wolin_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_full    (in_full),
  .out_empty  (out_empty),
  .out_pop    (out_pop),
  .out_sample (out_sample),
  .out_playing(out_playing)
);
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the wavetable oscillator with linear interpolation.
`timescale 1ns / 1ps

import wolin_pkg::*;

// Tracks table, phase, step and run state, and holds the tick results still owed.
class osc_scoreboard;
  localparam int ADDR_W    = TABLE_SIZE_LOG2_DEF;
  localparam int SAMPLE_W  = SAMPLE_BITS_DEF;
  localparam int FRAC_W    = FRACTION_BITS_DEF;
  localparam int PHASE_W   = ADDR_W + FRAC_W;
  localparam int TABLE_LEN = 1 << ADDR_W;
  localparam int PRINT_CAP = 50;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       playing;
  } tick_result_t;

  logic signed [SAMPLE_W-1:0] wave [TABLE_LEN];
  bit                         loaded [TABLE_LEN];
  bit [PHASE_W-1:0]           phase;
  bit [PHASE_W-1:0]           step;
  bit                         running;
  tick_result_t               owed_q [$];
  int                         mismatches;

  function new();
    foreach (wave[i]) begin
      wave[i]   = '0;
      loaded[i] = 1'b0;
    end
    phase      = '0;
    step       = '0;
    running    = 1'b0;
    mismatches = 0;
  endfunction

  function int pending();
    return owed_q.size();
  endfunction

  // A running tick reads the current entry and the next one; report one not yet loaded.
  function bit needs_load(output bit [ADDR_W-1:0] addr);
    bit [ADDR_W-1:0] idx;
    bit [ADDR_W-1:0] nxt;
    idx = phase[PHASE_W-1:FRAC_W];
    nxt = idx + 1'b1;
    addr = loaded[idx] ? nxt : idx;
    return !(loaded[idx] && loaded[nxt]);
  endfunction

  // Applies one accepted item and queues the result that a tick owes.
  function void note_input(logic [2:0] act, logic [ADDR_W-1:0] addr,
                           logic signed [SAMPLE_W-1:0] val, logic [PHASE_W-1:0] new_step);
    bit [ADDR_W-1:0] idx;
    bit [ADDR_W-1:0] nxt;
    longint          a;
    longint          b;
    longint          f;
    longint          acc;
    tick_result_t    res;
    case (act)
      ACT_TICK: begin
        if (running) begin
          idx = phase[PHASE_W-1:FRAC_W];
          nxt = idx + 1'b1;
          f   = phase[FRAC_W-1:0];
          a   = wave[idx];
          b   = wave[nxt];
          // Blend, then round to nearest with ties going upwards.
          acc = a * ((longint'(1) << FRAC_W) - f) + b * f;
          res.sample  = SAMPLE_W'((acc + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W);
          res.playing = 1'b1;
          phase = phase + step;
        end else begin
          res.sample  = '0;
          res.playing = 1'b0;
        end
        owed_q.push_back(res);
      end
      ACT_WRITE: begin
        wave[addr]   = val;
        loaded[addr] = 1'b1;
      end
      ACT_STEP:  step = new_step;
      ACT_START: running = 1'b1;
      ACT_STOP: begin
        running = 1'b0;
        phase   = '0;
      end
      default: ;
    endcase
  endfunction

  task report_mismatch(string msg);
    if (mismatches < PRINT_CAP)
      $display("[%0t] tick result error: %s", $realtime, msg);
    mismatches++;
  endtask

  // Compares one popped result with the oldest one owed.
  task check_result(logic signed [SAMPLE_W-1:0] sample, logic playing);
    tick_result_t want;
    if (owed_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result sample=%0d playing=%0b", sample, playing));
    end else begin
      want = owed_q.pop_front();
      if (sample !== want.sample)
        report_mismatch($sformatf("sample %0d, expected %0d", sample, want.sample));
      if (playing !== want.playing)
        report_mismatch($sformatf("playing %0b, expected %0b", playing, want.playing));
    end
  endtask
endclass

module tb_top;
  localparam int ADDR_W   = TABLE_SIZE_LOG2_DEF;
  localparam int SAMPLE_W = SAMPLE_BITS_DEF;
  localparam int FRAC_W   = FRACTION_BITS_DEF;
  localparam int PHASE_W  = ADDR_W + FRAC_W;
  localparam int RANDOM_ITEMS = 1900;
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
  localparam logic [PHASE_W-1:0] STEP_MAX      = '1;
  localparam logic [PHASE_W-1:0] STEP_HALF     = PHASE_W'(1) << (FRAC_W - 1);
  localparam logic [PHASE_W-1:0] STEP_ONE      = PHASE_W'(1) << FRAC_W;
  localparam logic [PHASE_W-1:0] STEP_BACK_ONE = STEP_MAX - STEP_ONE + 1'b1;
  localparam logic signed [SAMPLE_W-1:0] VAL_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] VAL_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_push = 1'b0;
  logic                       in_full;
  logic [2:0]                 in_action = ACT_TICK;
  logic [ADDR_W-1:0]          in_table_address = '0;
  logic signed [SAMPLE_W-1:0] in_table_value = '0;
  logic [PHASE_W-1:0]         in_phase_step = '0;
  logic                       out_empty;
  logic                       out_pop = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_playing;

  osc_scoreboard sb = new();
  bit            steady = 1'b0;
  int            pop_hold = 0;
  int            counted = 0;

  wavetable_oscillator_linear_interp dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_action        (in_action),
    .in_table_address (in_table_address),
    .in_table_value   (in_table_value),
    .in_phase_step    (in_phase_step),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_sample       (out_sample),
    .out_playing      (out_playing)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short idle gaps, now and then a long one.
  function automatic int gap_len();
    return ($urandom_range(0, 99) < 5) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  // Result side: pop with random stalls, except in steady stretches.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_result(out_sample, out_playing);
    if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      out_pop  <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 30) begin
      pop_hold <= gap_len() - 1;
      out_pop  <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  // Presents one item, waits until it is taken, then perhaps idles for a while.
  task automatic send_item(logic [2:0] act, logic [ADDR_W-1:0] addr,
                           logic signed [SAMPLE_W-1:0] val, logic [PHASE_W-1:0] new_step);
    in_push          <= 1'b1;
    in_action        <= act;
    in_table_address <= addr;
    in_table_value   <= val;
    in_phase_step    <= new_step;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_input(act, addr, val, new_step);
    if (!steady && $urandom_range(0, 99) < 30) begin
      in_push <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  // Non-write items carry random noise in the fields they do not use.
  task automatic send_op(logic [2:0] act);
    send_item(act, ADDR_W'($urandom()), SAMPLE_W'($urandom()), PHASE_W'($urandom()));
  endtask

  task automatic write_entry(logic [ADDR_W-1:0] addr, logic signed [SAMPLE_W-1:0] val);
    send_item(ACT_WRITE, addr, val, PHASE_W'($urandom()));
  endtask

  task automatic set_step(logic [PHASE_W-1:0] new_step);
    send_item(ACT_STEP, ADDR_W'($urandom()), SAMPLE_W'($urandom()), new_step);
  endtask

  // Holds the input side until every owed result has been popped.
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Extremes of fields, every action, wrap of the next entry, stop and restart.
  task automatic run_directed();
    send_op(ACT_TICK);
    for (int c = ACT_SPARE_FIRST; c <= ACT_SPARE_LAST; c++)
      send_op(3'(c));
    write_entry('0, VAL_MAX);
    write_entry(ADDR_W'(1), VAL_MIN);
    write_entry(ADDR_W'(2), SAMPLE_W'(16'h2AAA));
    write_entry('1, VAL_MIN);
    send_op(ACT_START);
    send_op(ACT_TICK);
    send_op(ACT_START);
    set_step(STEP_HALF);
    send_op(ACT_TICK);
    send_op(ACT_TICK);
    set_step(STEP_MAX);
    send_op(ACT_TICK);
    send_op(ACT_TICK);
    set_step(STEP_BACK_ONE);
    send_op(ACT_TICK);
    send_op(ACT_TICK);
    send_op(ACT_STOP);
    send_op(ACT_TICK);
    send_op(ACT_START);
    send_op(ACT_TICK);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic [PHASE_W-1:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return STEP_MAX;
      2:       return STEP_ONE;
      3, 4, 5: return PHASE_W'($urandom_range(0, 1 << (FRAC_W + 1)));
      default: return PHASE_W'($urandom());
    endcase
  endfunction

  // Random item: entries are loaded before any running tick would read them.
  task automatic random_item();
    bit [ADDR_W-1:0] addr;
    int              r;
    r = $urandom_range(0, 99);
    if (sb.running && sb.needs_load(addr)) begin
      write_entry(addr, pick_value());
      counted++;
    end else if (!sb.running && r < 30) begin
      send_op(ACT_START);
      counted++;
    end else if (r < 3) begin
      // Spare action codes are ignored, so they do not count.
      send_op(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)));
    end else begin
      if (r < 60)       send_op(ACT_TICK);
      else if (r < 75)  write_entry(ADDR_W'($urandom()), pick_value());
      else if (r < 85)  set_step(pick_step());
      else if (r < 90)  send_op(ACT_START);
      else if (r < 94)  send_op(ACT_STOP);
      else              send_op(ACT_TICK);
      counted++;
    end
  endtask

  // Run limit.
  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    drain();
    while (counted < RANDOM_ITEMS) begin
      steady = ((counted / 150) % 4 == 2);
      random_item();
      if (counted == RANDOM_ITEMS / 2)
        drain();
    end
    steady = 1'b0;
    drain();
    repeat (12) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
